// ===== src/segment_arrow_angle_unit_defines.svh =====
// assertion macros shared by the segment arrow angle unit
`ifndef SEGMENT_ARROW_ANGLE_UNIT_DEFINES_SVH
`define SEGMENT_ARROW_ANGLE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SAA_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SAA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/saa_pkg.sv =====
// shared types, constants and the cordic arctangent table
package saa_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int FRAC_BITS_DEF     = 8;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int GUARD     = 24;
    localparam int ANG_Q     = 24;
    localparam int Z_W       = 32;
    localparam int OUT_W     = 17;
    localparam int TAB_IDX_W = 5;

    localparam logic [Z_W-1:0] ANG_LIM = Z_W'(90) << ANG_Q;

    typedef struct packed {
        logic degenerate;
        logic sel;
        logic dx_neg;
        logic dx_zero;
        logic dy_neg;
        logic dy_zero;
    } ctrl_t;

    // atan(2^-i) in degrees, q.24
    function automatic logic [Z_W-1:0] atan_q24(input logic [TAB_IDX_W-1:0] idx);
        logic [Z_W-1:0] val;
        begin
            unique case (idx)
                5'd0:    val = 32'd754974720;
                5'd1:    val = 32'd445687602;
                5'd2:    val = 32'd235489088;
                5'd3:    val = 32'd119537938;
                5'd4:    val = 32'd60000934;
                5'd5:    val = 32'd30029717;
                5'd6:    val = 32'd15018523;
                5'd7:    val = 32'd7509720;
                5'd8:    val = 32'd3754917;
                5'd9:    val = 32'd1877466;
                5'd10:   val = 32'd938734;
                5'd11:   val = 32'd469367;
                5'd12:   val = 32'd234684;
                5'd13:   val = 32'd117342;
                5'd14:   val = 32'd58671;
                5'd15:   val = 32'd29335;
                5'd16:   val = 32'd14668;
                5'd17:   val = 32'd7334;
                5'd18:   val = 32'd3667;
                5'd19:   val = 32'd1833;
                5'd20:   val = 32'd917;
                5'd21:   val = 32'd458;
                5'd22:   val = 32'd229;
                5'd23:   val = 32'd115;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== src/saa_prep.sv =====
// input stage: point differences, magnitudes and segment classification
module saa_prep
    import saa_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int W           = COORD_WIDTH_DEF + GUARD + 3
) (
    input  logic                   clk,
    input  logic                   rstn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] start_x,
    input  logic [COORD_WIDTH-1:0] end_x,
    input  logic [COORD_WIDTH-1:0] start_y,
    input  logic [COORD_WIDTH-1:0] end_y,
    input  logic                   end_select,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [W-1:0]    out_x,
    output logic signed [W-1:0]    out_y,
    output ctrl_t                  out_ctrl
);

    localparam int PAD = W - COORD_WIDTH - GUARD;

    logic                   valid_reg;
    logic signed [W-1:0]    x_reg, x_next;
    logic signed [W-1:0]    y_reg, y_next;
    ctrl_t                  ctrl_reg, ctrl_next;
    logic [COORD_WIDTH:0]   dx, dy, ndx, ndy;
    logic [COORD_WIDTH-1:0] ax, ay;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        dx  = {start_x[COORD_WIDTH-1], start_x} - {end_x[COORD_WIDTH-1], end_x};
        dy  = {start_y[COORD_WIDTH-1], start_y} - {end_y[COORD_WIDTH-1], end_y};
        ndx = -dx;
        ndy = -dy;
        ax  = dx[COORD_WIDTH] ? ndx[COORD_WIDTH-1:0] : dx[COORD_WIDTH-1:0];
        ay  = dy[COORD_WIDTH] ? ndy[COORD_WIDTH-1:0] : dy[COORD_WIDTH-1:0];
        x_next = {{PAD{1'b0}}, ax, {GUARD{1'b0}}};
        y_next = {{PAD{1'b0}}, ay, {GUARD{1'b0}}};
        ctrl_next.dx_neg     = dx[COORD_WIDTH];
        ctrl_next.dx_zero    = (dx == '0);
        ctrl_next.dy_neg     = dy[COORD_WIDTH];
        ctrl_next.dy_zero    = (dy == '0);
        ctrl_next.degenerate = (dx == '0) && (dy == '0);
        ctrl_next.sel        = end_select;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ctrl_reg <= ctrl_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

// ===== src/saa_cordic_stage.sv =====
// one registered cordic vectoring iteration
module saa_cordic_stage
    import saa_pkg::*;
#(
    parameter int W     = COORD_WIDTH_DEF + GUARD + 3,
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 rstn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [W-1:0]  in_x,
    input  logic signed [W-1:0]  in_y,
    input  logic signed [Z_W-1:0] in_z,
    input  ctrl_t                in_ctrl,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [W-1:0]  out_x,
    output logic signed [W-1:0]  out_y,
    output logic signed [Z_W-1:0] out_z,
    output ctrl_t                out_ctrl
);

    localparam logic [Z_W-1:0] ATAN_VAL = atan_q24(TAB_IDX_W'(STAGE));

    logic                  valid_reg;
    logic signed [W-1:0]   x_reg, x_next;
    logic signed [W-1:0]   y_reg, y_next;
    logic signed [Z_W-1:0] z_reg, z_next;
    ctrl_t                 ctrl_reg;
    logic signed [W-1:0]   xs, ys;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        xs = in_x >>> STAGE;
        ys = in_y >>> STAGE;
        if (!in_y[W-1]) begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + $signed(ATAN_VAL);
        end else begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - $signed(ATAN_VAL);
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            ctrl_reg <= in_ctrl;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

// ===== src/saa_post.sv =====
// output stages: clamp and round the angle, then apply the quadrant table
`include "segment_arrow_angle_unit_defines.svh"

module saa_post
    import saa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rstn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [Z_W-1:0] in_z,
    input  ctrl_t                 in_ctrl,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_W-1:0]      angle_deg,
    output logic                  degenerate
);

    localparam int SH   = ANG_Q - FRAC_BITS;
    localparam int AW_A = FRAC_BITS + 7;
    localparam int EW   = (FRAC_BITS + 9 > OUT_W) ? FRAC_BITS + 9 : OUT_W;

    localparam logic [Z_W-2:0]  HALF  = (Z_W-1)'(1) << (SH - 1);
    localparam logic [Z_W-2:0]  LIM   = ANG_LIM[Z_W-2:0];
    localparam logic [AW_A-1:0] A_MAX = AW_A'(90) << FRAC_BITS;
    localparam logic [EW-1:0]   D90   = EW'(90) << FRAC_BITS;
    localparam logic [EW-1:0]   D180  = EW'(180) << FRAC_BITS;
    localparam logic [EW-1:0]   D270  = EW'(270) << FRAC_BITS;

    logic            valid_a_reg;
    logic [AW_A-1:0] a_reg, a_next;
    ctrl_t           ctrl_a_reg;
    logic            ready_b;
    logic [Z_W-2:0]  zc, rnd, rnd_sh;

    logic            valid_b_reg;
    logic [EW-1:0]   angle_reg, angle_next;
    logic            degen_reg;
    logic [EW-1:0]   a_ext, base;
    logic            add_a, sub_a;

    // clamp to 0..90 degrees and round half up
    always_comb begin
        if (in_z[Z_W-1]) begin
            zc = '0;
        end else if (in_z[Z_W-2:0] > LIM) begin
            zc = LIM;
        end else begin
            zc = in_z[Z_W-2:0];
        end
        rnd    = zc + HALF;
        rnd_sh = rnd >> SH;
        a_next = rnd_sh[AW_A-1:0];
    end

    assign ready_b  = !valid_b_reg || out_ready;
    assign in_ready = !valid_a_reg || ready_b;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_a_reg <= 1'b0;
        end else if (in_ready) begin
            valid_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            a_reg      <= a_next;
            ctrl_a_reg <= in_ctrl;
        end
    end

    // quadrant table
    always_comb begin
        a_ext = EW'(a_reg);
        base  = '0;
        add_a = 1'b0;
        sub_a = 1'b0;
        priority if (ctrl_a_reg.degenerate) begin
            base = '0;
        end else if (ctrl_a_reg.dx_zero) begin
            base = ctrl_a_reg.dy_neg ? (ctrl_a_reg.sel ? D180 : '0)
                                     : (ctrl_a_reg.sel ? '0 : D180);
        end else if (!ctrl_a_reg.dx_neg) begin
            base  = ctrl_a_reg.sel ? D90 : D270;
            sub_a = !ctrl_a_reg.dy_zero && !ctrl_a_reg.dy_neg;
            add_a = !ctrl_a_reg.dy_zero && ctrl_a_reg.dy_neg;
        end else begin
            base  = ctrl_a_reg.sel ? D270 : D90;
            add_a = !ctrl_a_reg.dy_zero && !ctrl_a_reg.dy_neg;
            sub_a = !ctrl_a_reg.dy_zero && ctrl_a_reg.dy_neg;
        end
        priority if (add_a) begin
            angle_next = base + a_ext;
        end else if (sub_a) begin
            angle_next = base - a_ext;
        end else begin
            angle_next = base;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_b_reg <= 1'b0;
        end else if (ready_b) begin
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (valid_a_reg && ready_b) begin
            angle_reg <= angle_next;
            degen_reg <= ctrl_a_reg.degenerate;
        end
    end

    assign out_valid  = valid_b_reg;
    assign angle_deg  = angle_reg[OUT_W-1:0];
    assign degenerate = degen_reg;

    `SAA_ASSERT_IMPLY(a_range_chk, clk, rstn, valid_a_reg, a_reg <= A_MAX,
                      "rounded angle above 90 degrees")
    `SAA_ASSERT_IMPLY(degen_zero_chk, clk, rstn, valid_b_reg && degen_reg,
                      angle_reg == '0, "degenerate beat with nonzero angle")
    `SAA_ASSERT_IMPLY(stall_chain_chk, clk, rstn, valid_b_reg && !out_ready && valid_a_reg,
                      !in_ready, "full stages took a beat during stall")
    `SAA_ASSERT_NEXT(advance_chk, clk, rstn, valid_a_reg && ready_b, valid_b_reg,
                     "beat lost between output stages")

endmodule

// ===== src/segment_arrow_angle_unit.sv =====
// top level of the segment arrow angle unit
//
// Takes a segment's start and end points (s_ channel) and returns the
// rotation of the arrow head at the start (s_end_select = 0) or at the end
// (s_end_select = 1) as unsigned degrees with FRAC_BITS fraction bits on the
// m_ channel. Coincident points give angle 0 with m_degenerate set.
// Both channels are valid/ready; one beat in gives one beat out, in order.
// The pipeline has one input stage, one register per cordic iteration, and
// two output stages for rounding and the quadrant table. Throughput is one
// beat per cycle while m_ready stays high.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so when m_ready is low the pipeline fills its bubbles and
// s_ready drops only once every stage holds a beat.
// Synchronous active-low reset on aresetn clears all valid bits; beats in
// flight are dropped.
module segment_arrow_angle_unit
    import saa_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [COORD_WIDTH-1:0] s_start_x,
    input  logic [COORD_WIDTH-1:0] s_end_x,
    input  logic [COORD_WIDTH-1:0] s_start_y,
    input  logic [COORD_WIDTH-1:0] s_end_y,
    input  logic                   s_end_select,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [OUT_W-1:0]       m_angle_deg,
    output logic                   m_degenerate
);

    localparam int W = COORD_WIDTH + GUARD + 3;

    logic                  st_valid [0:CORDIC_STAGES];
    logic                  st_ready [0:CORDIC_STAGES];
    logic signed [W-1:0]   st_x     [0:CORDIC_STAGES];
    logic signed [W-1:0]   st_y     [0:CORDIC_STAGES];
    logic signed [Z_W-1:0] st_z     [0:CORDIC_STAGES];
    ctrl_t                 st_ctrl  [0:CORDIC_STAGES];

    assign st_z[0] = '0;

    saa_prep #(
        .COORD_WIDTH (COORD_WIDTH),
        .W           (W)
    ) u_prep (
        .clk        (aclk),
        .rstn       (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .start_x    (s_start_x),
        .end_x      (s_end_x),
        .start_y    (s_start_y),
        .end_y      (s_end_y),
        .end_select (s_end_select),
        .out_valid  (st_valid[0]),
        .out_ready  (st_ready[0]),
        .out_x      (st_x[0]),
        .out_y      (st_y[0]),
        .out_ctrl   (st_ctrl[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        saa_cordic_stage #(
            .W     (W),
            .STAGE (i)
        ) u_stage (
            .clk       (aclk),
            .rstn      (aresetn),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_x      (st_x[i]),
            .in_y      (st_y[i]),
            .in_z      (st_z[i]),
            .in_ctrl   (st_ctrl[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_x     (st_x[i+1]),
            .out_y     (st_y[i+1]),
            .out_z     (st_z[i+1]),
            .out_ctrl  (st_ctrl[i+1])
        );
    end

    saa_post #(
        .FRAC_BITS (FRAC_BITS)
    ) u_post (
        .clk        (aclk),
        .rstn       (aresetn),
        .in_valid   (st_valid[CORDIC_STAGES]),
        .in_ready   (st_ready[CORDIC_STAGES]),
        .in_z       (st_z[CORDIC_STAGES]),
        .in_ctrl    (st_ctrl[CORDIC_STAGES]),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .angle_deg  (m_angle_deg),
        .degenerate (m_degenerate)
    );

endmodule

// ===== test/segment_arrow_angle_unit_test.sv =====
// self-checking testbench for the segment arrow angle unit
`timescale 1ns / 100ps

module segment_arrow_angle_unit_test
    import saa_pkg::*;
();

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int STAGES       = CORDIC_STAGES_DEF;
    localparam int RANDOM_ITEMS = 878;
    localparam int DRAIN_CYCLES = STAGES + 10;
    localparam int STALL_LIMIT  = 1000;
    localparam int CALM_FIRST   = 400;
    localparam int CALM_LAST    = 600;

    // atan(2^-i) in degrees, q.24, nearest
    localparam longint ATAN_DEG_Q24 [24] = '{
        754974720, 445687602, 235489088, 119537938,
        60000934, 30029717, 15018523, 7509720,
        3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335,
        14668, 7334, 3667, 1833,
        917, 458, 229, 115
    };

    typedef struct {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_y;
        logic                 end_select;
    } seg_t;

    typedef struct {
        logic [OUT_W-1:0] angle;
        logic             degen;
    } arrow_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic signed [CW-1:0] s_start_x    = '0;
    logic signed [CW-1:0] s_end_x      = '0;
    logic signed [CW-1:0] s_start_y    = '0;
    logic signed [CW-1:0] s_end_y      = '0;
    logic                 s_end_select = 1'b0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [OUT_W-1:0]     m_angle_deg;
    logic                 m_degenerate;

    seg_t   pending_segments [$];
    arrow_t expected_arrows [$];

    int total_segments   = 0;
    int issued_count     = 0;
    int accepted_count   = 0;
    int received_count   = 0;
    int mismatches       = 0;
    int coincident_count = 0;
    int axis_count       = 0;
    int stall_cycles     = 0;

    segment_arrow_angle_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_x    (s_start_x),
        .s_end_x      (s_end_x),
        .s_start_y    (s_start_y),
        .s_end_y      (s_end_y),
        .s_end_select (s_end_select),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_angle_deg  (m_angle_deg),
        .m_degenerate (m_degenerate)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // first-quadrant cordic vectoring, result in degrees q.FRAC
    function automatic longint atan_q8(input longint ax, input longint ay);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        begin
            x = ax << GUARD;
            y = ay << GUARD;
            z = 0;
            for (int i = 0; i < STAGES && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_DEG_Q24[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_DEG_Q24[i];
                end
            end
            if (z < 0) z = 0;
            if (z > (longint'(90) << ANG_Q)) z = longint'(90) << ANG_Q;
            return (z + (longint'(1) << (ANG_Q - FRAC - 1))) >> (ANG_Q - FRAC);
        end
    endfunction

    function automatic arrow_t arrow_angle_of(input seg_t seg);
        arrow_t res;
        longint dx;
        longint dy;
        longint one;
        longint a;
        longint s_ang;
        longint e_ang;
        longint deg;
        begin
            dx    = longint'(seg.start_x) - longint'(seg.end_x);
            dy    = longint'(seg.start_y) - longint'(seg.end_y);
            one   = longint'(1) << FRAC;
            a     = 0;
            res.degen = 1'b0;
            if (dx == 0 && dy == 0) begin
                res.angle = '0;
                res.degen = 1'b1;
                return res;
            end
            if (dx != 0 && dy != 0) begin
                a = atan_q8(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
            end
            if (dx > 0) begin
                if (dy == 0) begin
                    s_ang = 270 * one;     e_ang = 90 * one;
                end else if (dy > 0) begin
                    s_ang = 270 * one - a; e_ang = 90 * one - a;
                end else begin
                    s_ang = 270 * one + a; e_ang = 90 * one + a;
                end
            end else if (dx == 0) begin
                if (dy > 0) begin
                    s_ang = 180 * one;     e_ang = 0;
                end else begin
                    s_ang = 0;             e_ang = 180 * one;
                end
            end else begin
                if (dy == 0) begin
                    s_ang = 90 * one;      e_ang = 270 * one;
                end else if (dy > 0) begin
                    s_ang = 90 * one + a;  e_ang = 270 * one + a;
                end else begin
                    s_ang = 90 * one - a;  e_ang = 270 * one - a;
                end
            end
            deg = seg.end_select ? e_ang : s_ang;
            res.angle = deg[OUT_W-1:0];
            return res;
        end
    endfunction

    task automatic add_segment(input int sx, input int ex, input int sy, input int ey,
                               input bit sel);
        seg_t seg;
        begin
            seg.start_x    = sx[CW-1:0];
            seg.end_x      = ex[CW-1:0];
            seg.start_y    = sy[CW-1:0];
            seg.end_y      = ey[CW-1:0];
            seg.end_select = sel;
            pending_segments.insert(pending_segments.size(), seg);
            total_segments++;
        end
    endtask

    function automatic int edge_coord();
        int pick;
        begin
            pick = $urandom_range(4);
            unique case (pick)
                0:       return -32768;
                1:       return 32767;
                2:       return 0;
                3:       return -1;
                default: return int'($urandom_range(65535)) - 32768;
            endcase
        end
    endfunction

    task automatic add_random_segment();
        int kind;
        int sx;
        int sy;
        int ex;
        int ey;
        bit sel;
        begin
            kind = $urandom_range(99);
            sx = int'($urandom_range(65535)) - 32768;
            sy = int'($urandom_range(65535)) - 32768;
            ex = int'($urandom_range(65535)) - 32768;
            ey = int'($urandom_range(65535)) - 32768;
            sel = 1'($urandom_range(1));
            if (kind < 35) begin
            end else if (kind < 65) begin
                ex = sx + int'($urandom_range(600)) - 300;
                ey = sy + int'($urandom_range(600)) - 300;
            end else if (kind < 80) begin
                if ($urandom_range(1)) ex = sx;
                else ey = sy;
            end else if (kind < 85) begin
                ex = sx;
                ey = sy;
            end else begin
                sx = edge_coord();
                sy = edge_coord();
                ex = edge_coord();
                ey = edge_coord();
            end
            add_segment(sx, ex, sy, ey, sel);
        end
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                seg_t seg;
                seg.start_x    = s_start_x;
                seg.end_x      = s_end_x;
                seg.start_y    = s_start_y;
                seg.end_y      = s_end_y;
                seg.end_select = s_end_select;
                expected_arrows.insert(expected_arrows.size(), arrow_angle_of(seg));
                if ((s_start_x == s_end_x) != (s_start_y == s_end_y)) axis_count++;
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (pending_segments.size() != 0 &&
                    ((issued_count >= CALM_FIRST && issued_count < CALM_LAST) ||
                     $urandom_range(99) >= 30)) begin
                    seg_t seg;
                    seg = pending_segments.pop_front();
                    s_start_x    <= seg.start_x;
                    s_end_x      <= seg.end_x;
                    s_start_y    <= seg.start_y;
                    s_end_y      <= seg.end_y;
                    s_end_select <= seg.end_select;
                    s_valid      <= 1'b1;
                    issued_count++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                received_count++;
                if (m_degenerate) coincident_count++;
                if (expected_arrows.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: angle %0d degenerate %0b",
                                 m_angle_deg, m_degenerate);
                end else begin
                    arrow_t want;
                    want = expected_arrows.pop_front();
                    if (m_angle_deg !== want.angle || m_degenerate !== want.degen) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat %0d: angle %0d degenerate %0b, expected %0d %0b",
                                     received_count, m_angle_deg, m_degenerate,
                                     want.angle, want.degen);
                    end
                end
            end
            m_ready <= (received_count >= CALM_FIRST && received_count < CALM_LAST) ||
                       $urandom_range(99) >= 30;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int qdx [8];
        int qdy [8];
        qdx = '{3, 3, 3, 0, 0, -3, -3, -3};
        qdy = '{0, 4, -4, 5, -5, 0, 4, -4};

        // coincident points
        add_segment(0, 0, 0, 0, 1'b0);
        add_segment(-32768, -32768, 32767, 32767, 1'b1);
        // every quadrant row, both ends
        for (int q = 0; q < 8; q++) begin
            for (int s = 0; s < 2; s++) begin
                add_segment(100, 100 - qdx[q], -50, -50 - qdy[q], s[0]);
            end
        end
        // steep segments that round to a full 90
        add_segment(1, 0, -32768, 32767, 1'b0);
        add_segment(0, 1, -32768, 32767, 1'b0);
        // shallow segment and full-span diagonal
        add_segment(32767, -32768, 1, 0, 1'b0);
        add_segment(-32768, 32767, -32768, 32767, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++) add_random_segment();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_count != total_segments) @(posedge aclk);
        while (expected_arrows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        mismatches += expected_arrows.size();

        $display("%0d segments sent, %0d angles checked, %0d mismatches",
                 total_segments, received_count, mismatches);
        $display("covered %0d coincident and %0d axis-aligned segments",
                 coincident_count, axis_count);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
